// ----- hdl/ifct_pkg.sv -----
package ifct_pkg;

   // Command codes carried by each request word.
   typedef enum logic [1:0] {
      CMD_TICK         = 2'd0,
      CMD_START_FERT   = 2'd1,
      CMD_START_FILT   = 2'd2,
      CMD_DISABLE_FILT = 2'd3
   } command_type;

   // Configuration register indexes.
   typedef logic [2:0] csr_index_type;
   localparam csr_index_type REG_INJ_FIRST = 3'd0;
   localparam csr_index_type REG_FILTER    = 3'd4;

   // Number of injectors that have a timing register.
   localparam int NUM_INJ_REGS = 4;

   // Bit positions of the timing fields inside a register.
   localparam int POS_INJ_ON_PERIOD  = 0;
   localparam int POS_INJ_OFF_PERIOD = 16;
   localparam int POS_INJ_CYCLES     = 32;
   localparam int POS_FILT_FIRST     = 0;
   localparam int POS_FILT_LATER     = 16;
   localparam int POS_FILT_ON_TIME   = 32;
   localparam int POS_FILT_REPEAT    = 48;

   // The filter outputs follow from the sequencer stage alone: one output is
   // on during each of the three on-time stages.
   localparam logic [2:0] FILTER_DRIVE_LUT [8] = '{
      3'b000, 3'b000, 3'b001, 3'b000, 3'b010, 3'b000, 3'b100, 3'b000
   };

   typedef struct packed {
      logic [3:0] injector_drive;
      logic [2:0] filter_drive;
      logic [2:0] filter_stage;
      logic [3:0] injectors_done;
   } rsp_type;

endpackage

// ----- hdl/injector_and_filter_cycle_timer.sv -----
// Injector and filter cycle timer.
//
// Request channel (req_valid / req_stall): each word carries a command and the
// fertigation pump flag. A tick advances the four injector on/off timers (only
// while the pump runs) and the seven-stage filtration sequencer. The other
// commands restart all injectors, start filtration or disable it.
// Response channel (rsp_valid / rsp_stall): exactly one word per request,
// showing injector drives, filter drives, the filtration stage and the
// injector done flags as they stand after that request.
// Configuration (csr_write / csr_index / csr_wdata): four injector timing
// registers and one filter timing register; the user must write these only
// while idle, and the block does not enforce it. A request can be accepted
// every cycle while req_stall is low; the counter updates are one compare and
// increment per injector and one for the sequencer, all in one state update.
// A two-entry output (response register plus skid register) lets a request be
// taken while a response waits; req_stall rises only when both are full.
// Reset is synchronous: it clears all counters, the stage, the timing
// registers and both output entries.
module injector_and_filter_cycle_timer #(
   parameter int NUM_INJECTORS = 4,
   parameter int COUNT_BITS    = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic        req_fert_pump_on,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_injector_drive,
   output logic [2:0]  rsp_filter_drive,
   output logic [2:0]  rsp_filter_stage,
   output logic [3:0]  rsp_injectors_done
);

   localparam int CW = COUNT_BITS;
   localparam int OW = COUNT_BITS + 1;
   // Injectors past the fourth have no timing register; theirs reads as zero.
   localparam int NUM_LIVE = (NUM_INJECTORS < ifct_pkg::NUM_INJ_REGS) ?
                             NUM_INJECTORS : ifct_pkg::NUM_INJ_REGS;

   typedef enum logic [2:0] {
      STG_OFF,
      STG_FIRST_DELAY,
      STG_ON1,
      STG_GAP1,
      STG_ON2,
      STG_GAP2,
      STG_ON3,
      STG_REPEAT
   } stage_type;

   // Timing registers.
   logic [CW-1:0] on_period_ff   [NUM_LIVE];
   logic [CW-1:0] off_period_ff  [NUM_LIVE];
   logic [CW-1:0] cycles_ff      [NUM_LIVE];
   logic [CW-1:0] first_delay_ff;
   logic [CW-1:0] later_delay_ff;
   logic [CW-1:0] on_time_ff;
   logic [CW-1:0] repeat_gap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LIVE; i++) begin
            on_period_ff[i]  <= '0;
            off_period_ff[i] <= '0;
            cycles_ff[i]     <= '0;
         end
         first_delay_ff <= '0;
         later_delay_ff <= '0;
         on_time_ff     <= '0;
         repeat_gap_ff  <= '0;
      end else if (csr_write) begin
         for (int i = 0; i < NUM_LIVE; i++) begin
            if (csr_index == ifct_pkg::REG_INJ_FIRST + 3'(i)) begin
               on_period_ff[i]  <= csr_wdata[ifct_pkg::POS_INJ_ON_PERIOD +: CW];
               off_period_ff[i] <= csr_wdata[ifct_pkg::POS_INJ_OFF_PERIOD +: CW];
               cycles_ff[i]     <= csr_wdata[ifct_pkg::POS_INJ_CYCLES +: CW];
            end
         end
         if (csr_index == ifct_pkg::REG_FILTER) begin
            first_delay_ff <= csr_wdata[ifct_pkg::POS_FILT_FIRST +: CW];
            later_delay_ff <= csr_wdata[ifct_pkg::POS_FILT_LATER +: CW];
            on_time_ff     <= csr_wdata[ifct_pkg::POS_FILT_ON_TIME +: CW];
            repeat_gap_ff  <= csr_wdata[ifct_pkg::POS_FILT_REPEAT +: CW];
         end
      end
   end

   // Handshake.
   ifct_pkg::command_type command;
   logic                  req_fire;
   logic                  skid_valid_ff;

   assign command   = ifct_pkg::command_type'(req_command);
   assign req_stall = skid_valid_ff;
   assign req_fire  = req_valid && !skid_valid_ff;

   // Per-injector timers. Each injector keeps its own counters and computes
   // its next state from the current word.
   logic [NUM_INJECTORS-1:0] inj_on_next;
   logic [NUM_INJECTORS-1:0] inj_done_next;

   for (genvar g = 0; g < NUM_INJECTORS; g++) begin : g_inj
      logic [CW-1:0] on_p;
      logic [CW-1:0] off_p;
      logic [CW-1:0] cyc;
      logic          on_ff, on_in;
      logic [CW-1:0] on_cnt_ff, on_cnt_in;
      logic [OW-1:0] off_cnt_ff, off_cnt_in;
      logic [CW-1:0] cyc_cnt_ff, cyc_cnt_in;

      if (g < NUM_LIVE) begin : g_reg
         assign on_p  = on_period_ff[g];
         assign off_p = off_period_ff[g];
         assign cyc   = cycles_ff[g];
      end else begin : g_zero
         assign on_p  = '0;
         assign off_p = '0;
         assign cyc   = '0;
      end

      always_comb begin
         on_in      = on_ff;
         on_cnt_in  = on_cnt_ff;
         off_cnt_in = off_cnt_ff;
         cyc_cnt_in = cyc_cnt_ff;
         if (command == ifct_pkg::CMD_START_FERT) begin
            on_in      = 1'b1;
            on_cnt_in  = '0;
            off_cnt_in = '0;
            cyc_cnt_in = '0;
         end else if (command == ifct_pkg::CMD_TICK && req_fert_pump_on) begin
            if (on_ff) begin
               if (on_cnt_ff == on_p) begin
                  on_in      = 1'b0;
                  on_cnt_in  = '0;
                  off_cnt_in = off_cnt_ff + OW'(1);
                  // The finished-cycle count saturates.
                  if (cyc_cnt_ff != {CW{1'b1}}) begin
                     cyc_cnt_in = cyc_cnt_ff + CW'(1);
                  end
               end else begin
                  on_cnt_in = on_cnt_ff + CW'(1);
               end
            end else if (off_cnt_ff >= {1'b0, off_p}) begin
               if (cyc_cnt_ff < cyc) begin
                  on_in      = 1'b1;
                  on_cnt_in  = on_cnt_ff + CW'(1);
                  off_cnt_in = '0;
               end else begin
                  // All cycles done: park the off count just past its period.
                  off_cnt_in = {1'b0, off_p} + OW'(1);
               end
            end else begin
               off_cnt_in = off_cnt_ff + OW'(1);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            on_ff      <= 1'b0;
            on_cnt_ff  <= '0;
            off_cnt_ff <= '0;
            cyc_cnt_ff <= '0;
         end else if (req_fire) begin
            on_ff      <= on_in;
            on_cnt_ff  <= on_cnt_in;
            off_cnt_ff <= off_cnt_in;
            cyc_cnt_ff <= cyc_cnt_in;
         end
      end

      assign inj_on_next[g]   = on_in;
      assign inj_done_next[g] = !on_in && (cyc_cnt_in >= cyc);
   end

   // Filtration sequencer next state.
   stage_type     stage_ff, stage_in;
   logic [CW-1:0] tick_count_ff, tick_count_in;
   logic [CW-1:0] tick_inc;
   logic [CW-1:0] limit;

   assign tick_inc = tick_count_ff + CW'(1);

   always_comb begin
      unique case (stage_ff)
         STG_FIRST_DELAY:          limit = first_delay_ff;
         STG_ON1, STG_ON2, STG_ON3: limit = on_time_ff;
         STG_GAP1, STG_GAP2:       limit = later_delay_ff;
         STG_REPEAT:               limit = repeat_gap_ff;
         default:                  limit = '0;
      endcase
   end

   always_comb begin
      stage_in      = stage_ff;
      tick_count_in = tick_count_ff;
      unique case (command)
         ifct_pkg::CMD_TICK: begin
            if (stage_ff == STG_OFF) begin
               tick_count_in = '0;
            end else if (tick_inc == limit) begin
               tick_count_in = '0;
               stage_in = (stage_ff == STG_REPEAT) ? STG_FIRST_DELAY :
                          stage_type'(stage_ff + 3'd1);
            end else begin
               tick_count_in = tick_inc;
            end
         end
         ifct_pkg::CMD_START_FILT: begin
            stage_in      = STG_FIRST_DELAY;
            tick_count_in = '0;
         end
         ifct_pkg::CMD_DISABLE_FILT: begin
            stage_in      = STG_OFF;
            tick_count_in = '0;
         end
         default: begin
         end
      endcase
   end

   // Response word for the accepted request.
   ifct_pkg::rsp_type rsp_in;
   logic [3:0]        drive_next;
   logic [3:0]        done_next;

   for (genvar b = 0; b < 4; b++) begin : g_bits
      if (b < NUM_INJECTORS) begin : g_used
         assign drive_next[b] = inj_on_next[b];
         assign done_next[b]  = inj_done_next[b];
      end else begin : g_unused
         assign drive_next[b] = 1'b0;
         assign done_next[b]  = 1'b0;
      end
   end

   always_comb begin
      rsp_in.injector_drive = drive_next;
      rsp_in.filter_drive   = ifct_pkg::FILTER_DRIVE_LUT[stage_in];
      rsp_in.filter_stage   = stage_in;
      rsp_in.injectors_done = done_next;
   end

   // Sequencer state and the two output entries.
   ifct_pkg::rsp_type rsp_ff;
   ifct_pkg::rsp_type skid_ff;
   logic              rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff      <= STG_OFF;
         tick_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            stage_ff      <= stage_in;
            tick_count_ff <= tick_count_in;
         end
         if (!rsp_valid_ff || !rsp_stall) begin
            if (skid_valid_ff) begin
               rsp_ff        <= skid_ff;
               rsp_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else if (req_fire) begin
               rsp_ff       <= rsp_in;
               rsp_valid_ff <= 1'b1;
            end else begin
               rsp_valid_ff <= 1'b0;
            end
         end else if (req_fire) begin
            skid_ff       <= rsp_in;
            skid_valid_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_injector_drive = rsp_ff.injector_drive;
   assign rsp_filter_drive   = rsp_ff.filter_drive;
   assign rsp_filter_stage   = rsp_ff.filter_stage;
   assign rsp_injectors_done = rsp_ff.injectors_done;

endmodule

// ----- hdl/ifct_checker.sv -----
module ifct_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_injector_drive,
   input logic [2:0]  rsp_filter_drive,
   input logic [2:0]  rsp_filter_stage,
   input logic [3:0]  rsp_injectors_done
);

   // A stalled response word holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_injector_drive) &&
         $stable(rsp_filter_drive) && $stable(rsp_filter_stage) &&
         $stable(rsp_injectors_done))
   else $error("stalled response word changed");

   // The filter outputs must agree with the reported stage.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_filter_drive == ifct_pkg::FILTER_DRIVE_LUT[rsp_filter_stage])
   else $error("filter drive does not match filtration stage");

   // An injector that is running cannot be reported as done.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_injector_drive & rsp_injectors_done) == 4'b0000)
   else $error("injector reported both on and done");

   // Reset empties the output.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
   else $error("output not empty after reset");

endmodule

bind injector_and_filter_cycle_timer ifct_checker u_ifct_checker (.*);
